@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/spi_pkg.sv @@
`timescale 1ns / 1ps
package spi_pkg;

    // default configuration
    localparam int ADDR_BITS_DEF   = 16;
    localparam int SLICE_SLOTS_DEF = 255;
    localparam int NUM_REGS_DEF    = 16;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // opcode groups (opcode bits 7:2, ALU by bits 7:4)
    localparam logic [7:0] OP_BRK    = 8'h00;
    localparam logic [5:0] OPG_LDZ   = 6'h04;
    localparam logic [5:0] OPG_LDA   = 6'h05;
    localparam logic [5:0] OPG_STZ   = 6'h08;
    localparam logic [5:0] OPG_STA   = 6'h09;
    localparam logic [3:0] OPG_ALU   = 4'h3;
    localparam logic [5:0] OPG_SLOT  = 6'h10;
    localparam logic [5:0] OPG_FLAG  = 6'h11;
    localparam logic [5:0] OPG_BR    = 6'h12;

    // branch conditions
    localparam logic [1:0] BR_ALWAYS = 2'd0;
    localparam logic [1:0] BR_NEVER  = 2'd1;
    localparam logic [1:0] BR_ZERO   = 2'd2;
    localparam logic [1:0] BR_CARRY  = 2'd3;

    // alu operations
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd1;
    localparam logic [2:0] ALU_MUL = 3'd2;
    localparam logic [2:0] ALU_SHL = 3'd3;
    localparam logic [2:0] ALU_SHR = 3'd4;
    localparam logic [2:0] ALU_AND = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_XOR = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic        same;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] res;
        logic        zero;
        logic        carry;
        logic        carry_upd;
    } t_alu_rsp;

endpackage

@@ sv/sound_program_interpreter_top.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: action; tdata: address, write_data
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: read_data, pc_now, zero, carry, halted
//
// write and unknown actions pass through the response state to the output register; a read waits on the memory first.
// a run decodes one slot after another, then a halt check: every byte goes through the
// single read port of the byte memory, register operands through the register file port.
// reset is synchronous, clears control, flags, pc and register valid bits; byte memory is not cleared.
// a result waiting on m_axis blocks only the next completion, not the next input.
module sound_program_interpreter_top #(
    parameter int ADDR_BITS   = spi_pkg::ADDR_BITS_DEF,
    parameter int SLICE_SLOTS = spi_pkg::SLICE_SLOTS_DEF,
    parameter int NUM_REGS    = spi_pkg::NUM_REGS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [spi_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // address[15:0], write_data[23:16]
    input  logic [spi_pkg::IN_USER_W-1:0]   s_axis_tuser,  // action[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [spi_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // read_data[7:0], pc_now[23:8],
                                                           // zero[24], carry[25], halted[26]
);
    import spi_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int RW = $clog2(NUM_REGS);
    localparam int SW = (SLICE_SLOTS > 1) ? $clog2(SLICE_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLICE_SLOTS - 1);
    localparam logic [4:0] NR = 5'(NUM_REGS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDW  = 4'd1;
    localparam logic [3:0] ST_RESP = 4'd2;
    localparam logic [3:0] ST_DEC  = 4'd3;
    localparam logic [3:0] ST_B1   = 4'd4;
    localparam logic [3:0] ST_B2   = 4'd5;
    localparam logic [3:0] ST_LDLO = 4'd6;
    localparam logic [3:0] ST_LDHI = 4'd7;
    localparam logic [3:0] ST_STR  = 4'd8;
    localparam logic [3:0] ST_STLO = 4'd9;
    localparam logic [3:0] ST_ALUA = 4'd10;
    localparam logic [3:0] ST_ALUB = 4'd11;
    localparam logic [3:0] ST_ALUW = 4'd12;
    localparam logic [3:0] ST_NEXT = 4'd13;
    localparam logic [3:0] ST_HALT = 4'd14;

    // register number wraps modulo the register count
    function automatic logic [RW-1:0] rix(input logic [3:0] nib);
        logic [4:0] v;
        v = {1'b0, nib};
        if (v >= NR) v = v - NR;
        if (v >= NR) v = v - NR;
        if (v >= NR) v = v - NR;
        return v[RW-1:0];
    endfunction

    logic [3:0]    r_state, n_state;
    logic [15:0]   r_pc, n_pc;
    logic          r_z, n_z, r_c, n_c;
    logic [SW-1:0] r_slot, n_slot;
    logic [7:0]    r_opc, n_opc;
    logic [7:0]    r_b1, n_b1;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]    r_lo, n_lo;
    logic [15:0]   r_wd, n_wd;
    logic [15:0]   r_a, n_a;
    logic [7:0]    r_rdata, n_rdata;
    logic          r_halt, n_halt;
    logic          r_out_v;
    logic [OUT_DATA_W-1:0] r_out_d;

    // byte memory port
    logic [7:0]    mem [2**AW];
    logic [7:0]    r_mem_q;
    logic [AW-1:0] mem_ra, mem_wa;
    logic          mem_we;
    logic [7:0]    mem_wd;

    // register file port
    logic [15:0]         rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_v;
    logic [15:0]         r_rf_q;
    logic                r_rf_vq;
    logic [RW-1:0]       rf_ra, rf_wa;
    logic                rf_we;
    logic [15:0]         rf_wd, rf_val;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic [15:0] tgt;
    logic        taken;
    logic        in_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign rf_val        = r_rf_vq ? r_rf_q : 16'd0;
    assign tgt           = {r_b1, r_mem_q};

    assign alu_req.op   = r_opc[2:0];
    assign alu_req.a    = r_a;
    assign alu_req.b    = rf_val;
    assign alu_req.same = (rix(r_b1[7:4]) == rix(r_b1[3:0]));

    spi_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // branch condition
    always_comb begin
        case (r_opc[1:0])
            BR_ALWAYS: taken = 1'b1;
            BR_NEVER:  taken = 1'b0;
            BR_ZERO:   taken = r_z;
            default:   taken = r_c;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_z     = r_z;
        n_c     = r_c;
        n_slot  = r_slot;
        n_opc   = r_opc;
        n_b1    = r_b1;
        n_addr  = r_addr;
        n_lo    = r_lo;
        n_wd    = r_wd;
        n_a     = r_a;
        n_rdata = r_rdata;
        n_halt  = r_halt;
        mem_ra  = r_pc[AW-1:0];
        mem_we  = 1'b0;
        mem_wa  = r_addr;
        mem_wd  = r_wd[7:0];
        rf_ra   = rix({2'b00, r_opc[1:0]});
        rf_we   = 1'b0;
        rf_wa   = rix({2'b00, r_opc[1:0]});
        rf_wd   = 16'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_rdata = 8'd0;
                    n_halt  = 1'b0;
                    unique case (s_axis_tuser)
                        ACT_WRITE: begin
                            mem_we  = 1'b1;
                            mem_wa  = s_axis_tdata[AW-1:0];
                            mem_wd  = s_axis_tdata[23:16];
                            n_state = ST_RESP;
                        end
                        ACT_READ: begin
                            mem_ra  = s_axis_tdata[AW-1:0];
                            n_state = ST_RDW;
                        end
                        ACT_RUN: begin
                            n_slot  = '0;
                            n_state = ST_DEC;
                        end
                        default: n_state = ST_RESP;
                    endcase
                end
            end
            ST_RDW: begin
                n_rdata = r_mem_q;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_v || m_axis_tready) n_state = ST_IDLE;
            end
            ST_DEC: begin
                n_opc   = r_mem_q;
                n_state = ST_NEXT;
                mem_ra  = AW'(r_pc + 16'd1);
                if (r_mem_q == OP_BRK) begin
                    n_state = ST_NEXT;
                end else if (r_mem_q[7:2] == OPG_LDZ || r_mem_q[7:2] == OPG_LDA ||
                             r_mem_q[7:2] == OPG_STZ || r_mem_q[7:2] == OPG_STA ||
                             r_mem_q[7:4] == OPG_ALU || r_mem_q[7:2] == OPG_BR) begin
                    n_state = ST_B1;
                end else if (r_mem_q[7:2] == OPG_SLOT) begin
                    rf_we = 1'b1;
                    rf_wa = rix({2'b00, r_mem_q[1:0]});
                    rf_wd = 16'(r_slot);
                    n_z   = (r_slot == '0);
                    n_pc  = r_pc + 16'd1;
                end else if (r_mem_q[7:2] == OPG_FLAG) begin
                    if (r_mem_q[0]) n_c = r_mem_q[1];
                    else            n_z = r_mem_q[1];
                    n_pc = r_pc + 16'd1;
                end else begin
                    n_pc = r_pc + 16'd1;
                end
            end
            ST_B1: begin
                n_b1 = r_mem_q;
                if (r_opc[7:2] == OPG_LDZ) begin
                    n_addr  = AW'(r_mem_q);
                    mem_ra  = AW'(r_mem_q);
                    n_state = ST_LDLO;
                end else if (r_opc[7:2] == OPG_STZ) begin
                    n_addr  = AW'(r_mem_q);
                    n_state = ST_STR;
                end else if (r_opc[7:4] == OPG_ALU) begin
                    rf_ra   = rix(r_mem_q[3:0]);
                    n_state = ST_ALUA;
                end else begin
                    mem_ra  = AW'(r_pc + 16'd2);
                    n_state = ST_B2;
                end
            end
            ST_B2: begin
                if (r_opc[7:2] == OPG_LDA) begin
                    n_addr  = tgt[AW-1:0];
                    mem_ra  = tgt[AW-1:0];
                    n_state = ST_LDLO;
                end else if (r_opc[7:2] == OPG_STA) begin
                    n_addr  = tgt[AW-1:0];
                    n_state = ST_STR;
                end else begin
                    n_pc    = taken ? tgt : (r_pc + 16'd4);
                    n_state = ST_NEXT;
                end
            end
            ST_LDLO: begin
                n_lo    = r_mem_q;
                mem_ra  = r_addr + AW'(1);
                n_state = ST_LDHI;
            end
            ST_LDHI: begin
                rf_we   = 1'b1;
                rf_wd   = {r_mem_q, r_lo};
                n_pc    = r_pc + (r_opc[2] ? 16'd3 : 16'd2);
                n_state = ST_NEXT;
            end
            ST_STR: begin
                n_wd    = rf_val;
                mem_we  = 1'b1;
                mem_wa  = r_addr + AW'(1);
                mem_wd  = rf_val[15:8];
                n_state = ST_STLO;
            end
            ST_STLO: begin
                mem_we  = 1'b1;
                n_pc    = r_pc + (r_opc[2] ? 16'd3 : 16'd2);
                n_state = ST_NEXT;
            end
            ST_ALUA: begin
                n_a     = rf_val;
                rf_ra   = rix(r_b1[7:4]);
                n_state = ST_ALUB;
            end
            ST_ALUB: begin
                n_state = ST_ALUW;
            end
            ST_ALUW: begin
                rf_we   = 1'b1;
                rf_wa   = rix(r_b1[3:0]);
                rf_wd   = alu_rsp.res;
                n_z     = alu_rsp.zero;
                if (alu_rsp.carry_upd) n_c = alu_rsp.carry;
                n_pc    = r_pc + 16'd2;
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (r_slot == LAST_SLOT) begin
                    n_state = ST_HALT;
                end else begin
                    n_slot  = r_slot + SW'(1);
                    n_state = ST_DEC;
                end
            end
            ST_HALT: begin
                n_halt  = (r_mem_q == OP_BRK);
                n_state = ST_RESP;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= 16'd0;
            r_z     <= 1'b0;
            r_c     <= 1'b0;
            r_slot  <= '0;
            r_out_v <= 1'b0;
            r_rf_v  <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_z     <= n_z;
            r_c     <= n_c;
            r_slot  <= n_slot;
            if (rf_we) r_rf_v[rf_wa] <= 1'b1;
            if (r_state == ST_RESP && (!r_out_v || m_axis_tready)) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_opc   <= n_opc;
        r_b1    <= n_b1;
        r_addr  <= n_addr;
        r_lo    <= n_lo;
        r_wd    <= n_wd;
        r_a     <= n_a;
        r_rdata <= n_rdata;
        r_halt  <= n_halt;
        if (r_state == ST_RESP && (!r_out_v || m_axis_tready)) begin
            r_out_d <= {5'd0, r_halt, r_c, r_z, r_pc, r_rdata};
        end
    end

    // byte memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_mem_q <= mem[mem_ra];
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (rf_we) rf[rf_wa] <= rf_wd;
        r_rf_q  <= rf[rf_ra];
        r_rf_vq <= r_rf_v[rf_ra];
    end

endmodule

@@ sv/spi_alu.sv @@
`timescale 1ns / 1ps
module spi_alu (
    input  logic              i_clk,
    input  spi_pkg::t_alu_req i_req,
    output spi_pkg::t_alu_rsp o_rsp
);
    import spi_pkg::*;

    logic [15:0] n_res;
    logic [15:0] r_res;
    logic [15:0] r_b;
    logic [2:0]  r_op;
    logic        r_same;

    // operation select
    always_comb begin
        case (i_req.op)
            ALU_ADD: n_res = i_req.a + i_req.b;
            ALU_SUB: n_res = i_req.a - i_req.b;
            ALU_MUL: n_res = i_req.a * i_req.b;
            ALU_SHL: n_res = (i_req.b[15:4] != 12'd0) ? 16'd0 : (i_req.a << i_req.b[3:0]);
            ALU_SHR: n_res = (i_req.b[15:4] != 12'd0) ? 16'd0 : (i_req.a >> i_req.b[3:0]);
            ALU_AND: n_res = i_req.a & i_req.b;
            ALU_OR:  n_res = i_req.a | i_req.b;
            default: n_res = i_req.a ^ i_req.b;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_b    <= i_req.b;
        r_op   <= i_req.op;
        r_same <= i_req.same;
    end

    // flags against the source as it reads after write-back
    always_comb begin
        o_rsp.res       = r_res;
        o_rsp.zero      = (r_res == 16'd0);
        o_rsp.carry_upd = (r_op == ALU_ADD) || (r_op == ALU_SUB) || (r_op == ALU_MUL);
        if (r_same) begin
            o_rsp.carry = 1'b0;
        end else if (r_op == ALU_SUB) begin
            o_rsp.carry = (r_res > r_b);
        end else begin
            o_rsp.carry = (r_res < r_b);
        end
    end

endmodule

@@ sv/spi_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spi_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [spi_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spi_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import spi_pkg::*;

    logic [1:0] r_act;
    logic       r_open;
    logic [1:0] r_out_act;
    logic [1:0] out_act;

    // kind of the transaction whose result is on m_axis
    assign out_act = (m_axis_tvalid && r_open) ? r_act : r_out_act;

    // remember the kind of the last accepted transaction and of the shown result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= ACT_READ;
            r_open    <= 1'b1;
            r_out_act <= ACT_READ;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_act <= s_axis_tuser;
            end
            r_open    <= !m_axis_tvalid || m_axis_tready;
            r_out_act <= out_act;
        end
    end

    `ASSERT_HOLDS(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `ASSERT_HOLDS(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
    `ASSERT_NEVER(a_halt_only_run, i_clk, i_rst_n, m_axis_tvalid && out_act != ACT_RUN && m_axis_tdata[26], "halted set for a non-run transaction")
    `ASSERT_NEVER(a_rdata_only_read, i_clk, i_rst_n, m_axis_tvalid && out_act != ACT_READ && m_axis_tdata[7:0] != 8'd0, "read data set for a non-read transaction")

endmodule

bind sound_program_interpreter_top spi_checker u_spi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/sound_program_interpreter_top_tb.sv @@
`timescale 1ns / 1ps
module sound_program_interpreter_top_tb;
    import spi_pkg::*;

    localparam int TARGET_ITEMS = 460;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [31:0] want;
    } t_action;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    sound_program_interpreter_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // cpu shadow state
    logic [15:0] regs [16];
    logic [15:0] pc;
    logic        zf, cf;
    logic [7:0]  mem_shadow [int];
    int          written_addrs [$];

    // dry-run overlay, used to find bytes a slice would touch before they exist
    bit          dry_run;
    logic [7:0]  dry_mem [int];
    bit          unwritten_seen [int];
    int          unwritten_q [$];

    t_action     pending_actions [$];
    logic [31:0] expected_results [$];
    t_action     cur;
    int          total_actions;
    int          n_accepted;
    int          n_errors;

    function automatic logic [7:0] rd8(int a);
        a = a & 16'hFFFF;
        if (dry_run && dry_mem.exists(a)) return dry_mem[a];
        if (mem_shadow.exists(a)) return mem_shadow[a];
        if (dry_run && !unwritten_seen.exists(a)) begin
            unwritten_seen[a] = 1'b1;
            unwritten_q.push_back(a);
        end
        return 8'h00;
    endfunction

    function automatic void wr8(int a, logic [7:0] v);
        a = a & 16'hFFFF;
        if (dry_run) begin
            dry_mem[a] = v;
        end else begin
            if (!mem_shadow.exists(a)) written_addrs.push_back(a);
            mem_shadow[a] = v;
        end
    endfunction

    // little-endian data word
    function automatic logic [15:0] word_at(int a);
        return {rd8(a + 1), rd8(a)};
    endfunction

    // big-endian absolute operand
    function automatic logic [15:0] abs_operand();
        return {rd8(pc + 1), rd8(pc + 2)};
    endfunction

    function automatic void alu_exec(logic [2:0] op, logic [7:0] sel);
        logic [3:0]  src, dst;
        logic [31:0] a, b, r;
        src = sel[7:4];
        dst = sel[3:0];
        a = regs[dst];
        b = regs[src];
        case (op)
            ALU_ADD: r = a + b;
            ALU_SUB: r = a - b;
            ALU_MUL: r = a * b;
            ALU_SHL: r = (b >= 16) ? 32'd0 : (a << b);
            ALU_SHR: r = (b >= 16) ? 32'd0 : (a >> b);
            ALU_AND: r = a & b;
            ALU_OR:  r = a | b;
            default: r = a ^ b;
        endcase
        regs[dst] = r[15:0];
        // source is read again after the write
        if (op == ALU_ADD || op == ALU_MUL) cf = regs[dst] < regs[src];
        else if (op == ALU_SUB) cf = regs[dst] > regs[src];
        zf = regs[dst] == 16'd0;
    endfunction

    function automatic void exec_instr(logic [15:0] slot);
        logic [7:0]  op;
        logic [15:0] t;
        bit          taken;
        op = rd8(pc);
        if (op == OP_BRK) return;
        if (op[7:2] == OPG_LDZ) begin
            regs[op[1:0]] = word_at(rd8(pc + 1));
            pc += 16'd2;
        end else if (op[7:2] == OPG_LDA) begin
            regs[op[1:0]] = word_at(abs_operand());
            pc += 16'd3;
        end else if (op[7:2] == OPG_STZ) begin
            t = rd8(pc + 1);
            wr8(t + 1, regs[op[1:0]][15:8]);
            wr8(t, regs[op[1:0]][7:0]);
            pc += 16'd2;
        end else if (op[7:2] == OPG_STA) begin
            t = abs_operand();
            wr8(t + 1, regs[op[1:0]][15:8]);
            wr8(t, regs[op[1:0]][7:0]);
            pc += 16'd3;
        end else if (op[7:4] == OPG_ALU) begin
            alu_exec(op[2:0], rd8(pc + 1));
            pc += 16'd2;
        end else if (op[7:2] == OPG_SLOT) begin
            regs[op[1:0]] = slot;
            zf = slot == 16'd0;
            pc += 16'd1;
        end else if (op[7:2] == OPG_FLAG) begin
            if (op[0]) cf = op[1];
            else zf = op[1];
            pc += 16'd1;
        end else if (op[7:2] == OPG_BR) begin
            t = abs_operand();
            case (op[1:0])
                BR_ALWAYS: taken = 1'b1;
                BR_NEVER:  taken = 1'b0;
                BR_ZERO:   taken = zf;
                default:   taken = cf;
            endcase
            // a branch not taken skips one extra byte
            pc = taken ? t : pc + 16'd4;
        end else begin
            pc += 16'd1;
        end
    endfunction

    function automatic void run_slice(output bit halt);
        for (int s = 0; s < SLICE_SLOTS_DEF; s++) exec_instr(s[15:0]);
        halt = rd8(pc) == OP_BRK;
    endfunction

    // apply one action to the shadow and queue it with its expected result
    function automatic void push_action(logic [1:0] act, logic [15:0] addr, logic [7:0] data);
        t_action    it;
        logic [7:0] rd;
        bit         halt;
        rd = 8'h00;
        halt = 1'b0;
        case (act)
            ACT_WRITE: wr8(addr, data);
            ACT_READ:  rd = rd8(addr);
            ACT_RUN:   run_slice(halt);
            default: ;
        endcase
        it.act = act;
        it.addr = addr;
        it.data = data;
        it.want = {5'd0, halt, cf, zf, pc, rd};
        pending_actions.push_back(it);
    endfunction

    // mostly valid opcodes so that programs get somewhere
    function automatic logic [7:0] program_byte();
        logic [1:0] n;
        n = $urandom_range(3);
        case ($urandom_range(11))
            0:       return OP_BRK;
            1:       return {OPG_LDZ, n};
            2:       return {OPG_LDA, n};
            3:       return {OPG_STZ, n};
            4:       return {OPG_STA, n};
            5, 6:    return {OPG_ALU, 4'($urandom_range(15))};
            7:       return {OPG_SLOT, n};
            8:       return {OPG_FLAG, n};
            9:       return {OPG_BR, n};
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // write every byte the slice would read before running it
    function automatic void plan_run();
        logic [15:0] sv_regs [16];
        logic [15:0] sv_pc;
        logic        sv_zf, sv_cf;
        bit          halt;
        forever begin
            sv_regs = regs;
            sv_pc = pc;
            sv_zf = zf;
            sv_cf = cf;
            dry_mem.delete();
            unwritten_seen.delete();
            unwritten_q.delete();
            dry_run = 1'b1;
            run_slice(halt);
            dry_run = 1'b0;
            regs = sv_regs;
            pc = sv_pc;
            zf = sv_zf;
            cf = sv_cf;
            if (unwritten_q.size() == 0) break;
            foreach (unwritten_q[i])
                push_action(ACT_WRITE, 16'(unwritten_q[i]), program_byte());
        end
        push_action(ACT_RUN, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    endfunction

    function automatic int phase_of();
        return (total_actions == 0) ? 0 : (n_accepted * 4) / total_actions;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        n_errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        int gap_pct;
        gap_pct = (phase_of() == 1) ? 52 : (phase_of() == 3) ? 38 : 0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(cur.want);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_actions.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    cur = pending_actions.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur.data, cur.addr};
                    s_axis_tuser <= cur.act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        int         stall_pct;
        logic [31:0] want;
        stall_pct = (phase_of() == 2) ? 52 : (phase_of() == 3) ? 38 : 0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_axis_tdata, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[7:0] != want[7:0])
                        report_mismatch("read_data", m_axis_tdata[7:0], want[7:0]);
                    if (m_axis_tdata[23:8] != want[23:8])
                        report_mismatch("pc_now", m_axis_tdata[23:8], want[23:8]);
                    if (m_axis_tdata[24] != want[24])
                        report_mismatch("zero", m_axis_tdata[24], want[24]);
                    if (m_axis_tdata[25] != want[25])
                        report_mismatch("carry", m_axis_tdata[25], want[25]);
                    if (m_axis_tdata[26] != want[26])
                        report_mismatch("halted", m_axis_tdata[26], want[26]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // stimulus and end of test
    initial begin
        int r;
        foreach (regs[i]) regs[i] = 16'd0;
        pc = 16'd0;
        zf = 1'b0;
        cf = 1'b0;
        dry_run = 1'b0;
        n_accepted = 0;
        n_errors = 0;
        total_actions = 0;

        // directed: address extremes, break, unknown action, then a short program
        push_action(ACT_WRITE, 16'hFFFF, 8'hFF);
        push_action(ACT_READ, 16'hFFFF, 8'h00);
        push_action(ACT_WRITE, 16'h0000, OP_BRK);
        plan_run();
        push_action(ACT_NONE, 16'hFFFF, 8'hFF);
        push_action(ACT_READ, 16'h0000, 8'h00);
        push_action(ACT_WRITE, 16'h0000, {OPG_SLOT, 2'd1});
        push_action(ACT_WRITE, 16'h0001, {OPG_ALU, 1'b0, ALU_SHL});
        push_action(ACT_WRITE, 16'h0002, 8'h11);                  // shift by itself
        push_action(ACT_WRITE, 16'h0003, {OPG_LDA, 2'd2});
        push_action(ACT_WRITE, 16'h0004, 8'hFF);                  // word at top wraps to zero
        push_action(ACT_WRITE, 16'h0005, 8'hFF);
        push_action(ACT_WRITE, 16'h0006, {OPG_BR, BR_CARRY});
        push_action(ACT_WRITE, 16'h0007, 8'h00);
        push_action(ACT_WRITE, 16'h0008, 8'h0C);
        push_action(ACT_WRITE, 16'h0009, {OPG_BR, BR_NEVER});
        plan_run();
        plan_run();

        // random: programs grow around the pc, mixed with raw traffic
        while (pending_actions.size() < TARGET_ITEMS) begin
            r = $urandom_range(99);
            if (r < 35)
                plan_run();
            else if (r < 55)
                push_action(ACT_WRITE, pc + 16'($urandom_range(3)), program_byte());
            else if (r < 68)
                push_action(ACT_WRITE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            else if (r < 85)
                push_action(ACT_READ,
                            16'(written_addrs[$urandom_range(written_addrs.size() - 1)]),
                            8'($urandom_range(255)));
            else if (r < 90)
                push_action(ACT_NONE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            else
                push_action(ACT_WRITE, 16'($urandom_range(255)), 8'($urandom_range(255)));
        end
        total_actions = pending_actions.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total_actions || expected_results.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sound_program_interpreter_top.f @@
+incdir+sv
sv/spi_pkg.sv
sv/spi_alu.sv
sv/sound_program_interpreter_top.sv
sv/spi_checker.sv
verif/sound_program_interpreter_top_tb.sv
